/* hdl/designated_initializer_parser_core_assert.svh */
// assertion macros shared by the parser modules
`ifndef DESIGNATED_INITIALIZER_PARSER_CORE_ASSERT_SVH
`define DESIGNATED_INITIALIZER_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define DIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define DIP_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define DIP_ASSERT(label, prop, msg)

`define DIP_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* hdl/dip_pkg.sv */
// types, codes and constants of the designated-initializer parser
`default_nettype none

package dip_pkg;

  localparam int unsigned MaxStringBytes = 1024;
  localparam int unsigned LenWidth       = $clog2(MaxStringBytes + 1);
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QPtrWidth      = $clog2(QueueDepth);
  localparam int unsigned QCntWidth      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharLBrace    = 8'h7B;
  localparam logic [7:0] CharRBrace    = 8'h7D;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [7:0] CharEquals    = 8'h3D;
  localparam logic [7:0] CharComma     = 8'h2C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLowerX    = 8'h78;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharDollar    = 8'h24;
  localparam logic [7:0] CharUnder     = 8'h5F;
  localparam logic [7:0] ByteNewline   = 8'h0A;
  localparam logic [7:0] ByteReturn    = 8'h0D;
  localparam logic [7:0] ByteNul       = 8'h00;

  typedef enum logic [3:0] {
    PH_OPEN     = 4'd0,
    PH_DOT      = 4'd1,
    PH_ID_FIRST = 4'd2,
    PH_ID_REST  = 4'd3,
    PH_VALUE    = 4'd4,
    PH_STRING   = 4'd5,
    PH_NUMBER   = 4'd6,
    PH_AFTER    = 4'd7,
    PH_DONE     = 4'd8,
    PH_FAILED   = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_PENDING = 2'd1,
    ESC_HEX_HI  = 2'd2,
    ESC_HEX_LO  = 2'd3
  } escape_e;

  typedef enum logic [2:0] {
    EV_NAME_BYTE = 3'd0,
    EV_NAME_END  = 3'd1,
    EV_STR_BYTE  = 3'd2,
    EV_STR_END   = 3'd3,
    EV_NUMBER    = 3'd4,
    EV_DONE      = 3'd5,
    EV_ERROR     = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    ERR_NO_BRACE   = 4'd0,
    ERR_NO_DOT     = 4'd1,
    ERR_BAD_NAME   = 4'd2,
    ERR_NO_EQUALS  = 4'd3,
    ERR_BAD_VALUE  = 4'd4,
    ERR_BAD_ESCAPE = 4'd5,
    ERR_BAD_HEX    = 4'd6,
    ERR_TOO_LONG   = 4'd7,
    ERR_NO_COMMA   = 4'd8,
    ERR_TRUNCATED  = 4'd9
  } error_e;

  // one queue entry: the results of one byte; the second result, if any,
  // is always a done or error event with no byte and no number
  typedef struct packed {
    logic        two;
    event_e      kind0;
    logic [7:0]  byte0;
    logic [63:0] num0;
    error_e      code0;
    event_e      kind1;
    error_e      code1;
  } dip_entry_t;

endpackage

`default_nettype wire

/* hdl/dip_if.sv */
// valid/ready channel interfaces for input bytes and result events
`default_nettype none

interface dip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface dip_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  out_byte;
  logic [63:0] number_value;
  logic [3:0]  error_code;
  logic        last_result;

  modport source (output valid, event_kind, out_byte, number_value, error_code, last_result,
                  input ready);
  modport sink   (input valid, event_kind, out_byte, number_value, error_code, last_result,
                  output ready);
endinterface

`default_nettype wire

/* hdl/dip_front.sv */
// front end: accepts bytes, runs the parse state machine, queues results
`default_nettype none
`include "designated_initializer_parser_core_assert.svh"

module dip_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  dip_in_if.sink                in_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output dip_pkg::dip_entry_t   push_entry_o
);
  import dip_pkg::*;

  phase_e              phase_q, phase_d, phase_pre, phase_cur;
  escape_e             esc_q, esc_d, esc_cur;
  logic [3:0]          hex_q, hex_d, hex_cur;
  logic [63:0]         acc_q, acc_d, acc_cur;
  logic [LenWidth-1:0] len_q, len_d, len_cur;
  logic                comma_q, comma_d, comma_cur;

  logic       in_fire;
  logic [7:0] c;
  logic       is_alpha, is_digit, is_namech, hex_ok, str_full, trunc;
  logic [3:0] nib;
  logic       esc_known;
  logic [7:0] esc_byte;

  // value-terminator decode, shared by number end and after-value phase
  logic   av_comma, av_comma_d, av_done, av_fail;
  phase_e av_phase;
  error_e av_code;

  // result slots
  logic [1:0]  n;
  event_e      res_kind [2];
  error_e      res_code [2];
  logic [7:0]  byte0;
  logic [63:0] num0;
  logic        sb_req;
  logic [7:0]  sb_val;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;
  assign c        = in_i.data_byte;

  // a restart byte sees the reset state
  assign phase_cur = in_i.first_byte ? PH_OPEN  : phase_q;
  assign esc_cur   = in_i.first_byte ? ESC_NONE : esc_q;
  assign hex_cur   = in_i.first_byte ? 4'd0     : hex_q;
  assign acc_cur   = in_i.first_byte ? 64'd0    : acc_q;
  assign len_cur   = in_i.first_byte ? '0       : len_q;
  assign comma_cur = in_i.first_byte ? 1'b0     : comma_q;

  assign is_alpha  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit  = (c >= 8'h30 && c <= 8'h39);
  assign is_namech = is_alpha || is_digit || c == CharDollar || c == CharUnder;
  assign hex_ok    = is_digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  assign nib       = is_digit ? c[3:0] : c[3:0] + 4'd9;
  assign str_full  = len_cur >= LenWidth'(MaxStringBytes);

  always_comb begin
    esc_known = 1'b1;
    esc_byte  = ByteNul;
    case (c)
      CharQuote:  esc_byte = CharQuote;
      CharLowerN: esc_byte = ByteNewline;
      CharLowerR: esc_byte = ByteReturn;
      CharZero:   esc_byte = ByteNul;
      default:    esc_known = 1'b0;
    endcase
  end

  assign av_comma = (phase_cur == PH_AFTER) ? comma_cur : 1'b0;

  always_comb begin
    av_phase   = PH_FAILED;
    av_comma_d = av_comma;
    av_done    = 1'b0;
    av_fail    = 1'b0;
    av_code    = ERR_NO_COMMA;
    if (!av_comma) begin
      if (c == CharComma) begin
        av_phase   = PH_AFTER;
        av_comma_d = 1'b1;
      end else if (c == CharRBrace) begin
        av_phase = PH_DONE;
        av_done  = 1'b1;
      end else begin
        av_fail = 1'b1;
        av_code = ERR_NO_COMMA;
      end
    end else begin
      if (c == CharRBrace) begin
        av_phase = PH_DONE;
        av_done  = 1'b1;
      end else if (c == CharDot) begin
        av_phase   = PH_ID_FIRST;
        av_comma_d = 1'b0;
      end else begin
        av_fail = 1'b1;
        av_code = ERR_NO_DOT;
      end
    end
  end

  // next state
  always_comb begin
    phase_pre = phase_cur;
    esc_d     = esc_cur;
    hex_d     = hex_cur;
    acc_d     = acc_cur;
    len_d     = len_cur;
    comma_d   = comma_cur;
    unique case (phase_cur)
      PH_OPEN:     phase_pre = (c == CharLBrace) ? PH_DOT : PH_FAILED;
      PH_DOT:      phase_pre = (c == CharDot) ? PH_ID_FIRST : PH_FAILED;
      PH_ID_FIRST: phase_pre = is_alpha ? PH_ID_REST : PH_FAILED;
      PH_ID_REST: begin
        if (!is_namech) phase_pre = (c == CharEquals) ? PH_VALUE : PH_FAILED;
      end
      PH_VALUE: begin
        if (c == CharQuote) begin
          esc_d     = ESC_NONE;
          len_d     = '0;
          phase_pre = PH_STRING;
        end else if (is_digit) begin
          acc_d     = {60'd0, c[3:0]};
          phase_pre = PH_NUMBER;
        end else begin
          phase_pre = PH_FAILED;
        end
      end
      PH_STRING: begin
        unique case (esc_cur)
          ESC_NONE: begin
            if (c == CharQuote) begin
              comma_d   = 1'b0;
              phase_pre = PH_AFTER;
            end else if (c == CharBackslash) begin
              esc_d = ESC_PENDING;
            end else if (str_full) begin
              phase_pre = PH_FAILED;
            end else begin
              len_d = len_cur + LenWidth'(1);
            end
          end
          ESC_PENDING: begin
            if (c != CharBackslash) begin
              esc_d = ESC_NONE;
              if (esc_known) begin
                if (str_full) phase_pre = PH_FAILED;
                else len_d = len_cur + LenWidth'(1);
              end else if (c == CharLowerX) begin
                esc_d = ESC_HEX_HI;
              end else begin
                phase_pre = PH_FAILED;
              end
            end
          end
          ESC_HEX_HI: begin
            if (hex_ok) begin
              hex_d = nib;
              esc_d = ESC_HEX_LO;
            end else begin
              phase_pre = PH_FAILED;
            end
          end
          default: begin
            esc_d = ESC_NONE;
            if (!hex_ok || str_full) phase_pre = PH_FAILED;
            else len_d = len_cur + LenWidth'(1);
          end
        endcase
      end
      PH_NUMBER: begin
        if (is_digit) begin
          // acc * 10 + digit as shifts and adds
          acc_d = {acc_cur[60:0], 3'b000} + {acc_cur[62:0], 1'b0} + {60'd0, c[3:0]};
        end else begin
          phase_pre = av_phase;
          comma_d   = av_comma_d;
        end
      end
      PH_AFTER: begin
        phase_pre = av_phase;
        comma_d   = av_comma_d;
      end
      default: ;
    endcase
  end

  assign trunc   = in_i.last_byte && phase_pre != PH_DONE && phase_pre != PH_FAILED;
  assign phase_d = trunc ? PH_FAILED : phase_pre;

  // results of this byte
  always_comb begin
    n           = 2'd0;
    res_kind[0] = EV_NAME_BYTE;
    res_kind[1] = EV_NAME_BYTE;
    res_code[0] = ERR_NO_BRACE;
    res_code[1] = ERR_NO_BRACE;
    byte0       = 8'd0;
    num0        = 64'd0;
    sb_req      = 1'b0;
    sb_val      = c;
    unique case (phase_cur)
      PH_OPEN: begin
        if (c != CharLBrace) begin
          res_kind[0] = EV_ERROR;
          res_code[0] = ERR_NO_BRACE;
          n = 2'd1;
        end
      end
      PH_DOT: begin
        if (c != CharDot) begin
          res_kind[0] = EV_ERROR;
          res_code[0] = ERR_NO_DOT;
          n = 2'd1;
        end
      end
      PH_ID_FIRST: begin
        if (is_alpha) begin
          res_kind[0] = EV_NAME_BYTE;
          byte0 = c;
        end else begin
          res_kind[0] = EV_ERROR;
          res_code[0] = ERR_BAD_NAME;
        end
        n = 2'd1;
      end
      PH_ID_REST: begin
        n = 2'd1;
        if (is_namech) begin
          res_kind[0] = EV_NAME_BYTE;
          byte0 = c;
        end else begin
          res_kind[0] = EV_NAME_END;
          if (c != CharEquals) begin
            res_kind[1] = EV_ERROR;
            res_code[1] = ERR_NO_EQUALS;
            n = 2'd2;
          end
        end
      end
      PH_VALUE: begin
        if (c != CharQuote && !is_digit) begin
          res_kind[0] = EV_ERROR;
          res_code[0] = ERR_BAD_VALUE;
          n = 2'd1;
        end
      end
      PH_STRING: begin
        unique case (esc_cur)
          ESC_NONE: begin
            if (c == CharQuote) begin
              res_kind[0] = EV_STR_END;
              n = 2'd1;
            end else if (c != CharBackslash) begin
              sb_req = 1'b1;
            end
          end
          ESC_PENDING: begin
            if (esc_known) begin
              sb_req = 1'b1;
              sb_val = esc_byte;
            end else if (c != CharBackslash && c != CharLowerX) begin
              res_kind[0] = EV_ERROR;
              res_code[0] = ERR_BAD_ESCAPE;
              n = 2'd1;
            end
          end
          ESC_HEX_HI: begin
            if (!hex_ok) begin
              res_kind[0] = EV_ERROR;
              res_code[0] = ERR_BAD_HEX;
              n = 2'd1;
            end
          end
          default: begin
            if (hex_ok) begin
              sb_req = 1'b1;
              sb_val = {hex_cur, nib};
            end else begin
              res_kind[0] = EV_ERROR;
              res_code[0] = ERR_BAD_HEX;
              n = 2'd1;
            end
          end
        endcase
        if (sb_req) begin
          n = 2'd1;
          if (str_full) begin
            res_kind[0] = EV_ERROR;
            res_code[0] = ERR_TOO_LONG;
          end else begin
            res_kind[0] = EV_STR_BYTE;
            byte0 = sb_val;
          end
        end
      end
      PH_NUMBER: begin
        if (!is_digit) begin
          res_kind[0] = EV_NUMBER;
          num0 = acc_cur;
          n = 2'd1;
          if (av_done || av_fail) begin
            res_kind[1] = av_done ? EV_DONE : EV_ERROR;
            res_code[1] = av_fail ? av_code : ERR_NO_BRACE;
            n = 2'd2;
          end
        end
      end
      PH_AFTER: begin
        if (av_done || av_fail) begin
          res_kind[0] = av_done ? EV_DONE : EV_ERROR;
          res_code[0] = av_fail ? av_code : ERR_NO_BRACE;
          n = 2'd1;
        end
      end
      default: ;
    endcase

    // end of buffer before done: a running number is flushed, then truncated
    if (trunc) begin
      if (phase_pre == PH_NUMBER) begin
        res_kind[0] = EV_NUMBER;
        num0 = acc_d;
        n = 2'd1;
      end
      res_kind[n[0]] = EV_ERROR;
      res_code[n[0]] = ERR_TRUNCATED;
      n = n + 2'd1;
    end
  end

  assign push_o             = in_fire && (n != 2'd0);
  assign push_entry_o.two   = n[1];
  assign push_entry_o.kind0 = res_kind[0];
  assign push_entry_o.byte0 = byte0;
  assign push_entry_o.num0  = num0;
  assign push_entry_o.code0 = res_code[0];
  assign push_entry_o.kind1 = res_kind[1];
  assign push_entry_o.code1 = res_code[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      esc_q   <= ESC_NONE;
      hex_q   <= 4'd0;
      acc_q   <= 64'd0;
      len_q   <= '0;
      comma_q <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      hex_q   <= hex_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      comma_q <= comma_d;
    end
  end

  `DIP_ASSERT(a_front_quiet_after_end,
              (in_fire && !in_i.first_byte && (phase_q == PH_DONE || phase_q == PH_FAILED))
              |-> !push_o,
              "front queued a result after done or error")

endmodule

`default_nettype wire

/* hdl/dip_queue.sv */
// short result queue between the parse front end and the output back end
`default_nettype none
`include "designated_initializer_parser_core_assert.svh"

module dip_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire dip_pkg::dip_entry_t  push_entry_i,
  input  wire logic                 pop_i,
  output logic                      full_o,
  output logic                      head_valid_o,
  output dip_pkg::dip_entry_t       head_entry_o
);
  import dip_pkg::*;

  dip_entry_t           entries_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o       = count_q == QCntWidth'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_entry_o = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + QCntWidth'(1);
      2'b01:   count_d = count_q - QCntWidth'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrWidth'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrWidth'(1);
      count_q <= count_d;
    end
  end

  `DIP_ASSERT_NEVER(a_queue_overflow, push_i && full_o, "push into a full queue")
  `DIP_ASSERT_NEVER(a_queue_underflow, pop_i && !head_valid_o, "pop from an empty queue")

endmodule

`default_nettype wire

/* hdl/dip_back.sv */
// back end: splits queued entries into single result transactions
`default_nettype none
`include "designated_initializer_parser_core_assert.svh"

module dip_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 head_valid_i,
  input  wire dip_pkg::dip_entry_t  head_entry_i,
  output logic                      pop_o,
  dip_out_if.source                 out_o
);
  import dip_pkg::*;

  logic        out_valid_q, out_valid_d;
  event_e      kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [63:0] num_q, num_d;
  error_e      code_q, code_d;
  logic        last_q, last_d;
  logic        sel_q, sel_d;
  logic        load;

  // output register is free or being emptied this cycle
  assign load = head_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    kind_d = kind_q;
    byte_d = byte_q;
    num_d  = num_q;
    code_d = code_q;
    last_d = last_q;
    sel_d  = sel_q;
    pop_o  = 1'b0;
    if (load) begin
      if (!sel_q) begin
        kind_d = head_entry_i.kind0;
        byte_d = head_entry_i.byte0;
        num_d  = head_entry_i.num0;
        code_d = head_entry_i.code0;
        last_d = !head_entry_i.two;
        pop_o  = !head_entry_i.two;
        sel_d  = head_entry_i.two;
      end else begin
        kind_d = head_entry_i.kind1;
        byte_d = 8'd0;
        num_d  = 64'd0;
        code_d = head_entry_i.code1;
        last_d = 1'b1;
        pop_o  = 1'b1;
        sel_d  = 1'b0;
      end
    end
  end

  assign out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    num_q  <= num_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_kind   = kind_q;
  assign out_o.out_byte     = byte_q;
  assign out_o.number_value = num_q;
  assign out_o.error_code   = code_q;
  assign out_o.last_result  = last_q;

  `DIP_ASSERT(a_back_second_has_head, sel_q |-> head_valid_i,
              "second result pending without a queued entry")

endmodule

`default_nettype wire

/* hdl/designated_initializer_parser_core.sv */
// top level of the designated-initializer text parser
//
// usage
//   in_ch_i carries one text byte per transaction with first_byte (restart the
//   parser at this byte) and last_byte (final byte of the buffer).
//   out_ch_o carries one event per transaction: name byte, name end, string
//   byte, string end, number, done or error; last_result marks the final
//   event caused by an input byte (one or two events per byte).
//   latency: an event passes from the front end into the result queue and then
//   into the output register that drives out_ch_o; a second event follows it from the same entry.
//   throughput: one byte per cycle while the result queue is not full; the parse
//   state machine in the front end decodes each byte combinationally (the decimal
//   accumulator is a shift-add loop); bytes that raise two events take two output
//   transactions, which the four-entry result queue absorbs.
//   bytes with no event (open brace, dot, comma, opening quote, digits of a
//   number, backslash, x and the high hex digit) never occupy the queue.
//   reset clears the parser to expect an open brace and empties the queue.
//   when the receiver stalls, the output register holds its event, the
//   queue fills and in_ch_i.ready drops only once the queue is full.
`default_nettype none

module designated_initializer_parser_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dip_in_if.sink     in_ch_i,
  dip_out_if.source  out_ch_o
);
  import dip_pkg::*;

  // front to queue
  logic       push;
  dip_entry_t push_entry;
  logic       full;

  // queue to back
  logic       head_valid;
  dip_entry_t head_entry;
  logic       pop;

  // parse state machine, one byte per cycle while the result queue is not full
  dip_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // decouples parsing from the output handshake
  dip_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  // registered output, one event per transaction
  dip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_o        (out_ch_o)
  );

endmodule

`default_nettype wire

/* tb/dip_event_checker.sv */
`timescale 1ns / 100ps
// event predictor and scoreboard for the designated-initializer parser
module dip_event_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dip_in_if           in_mon,
  dip_out_if          out_mon,
  output int unsigned mismatch_count_o,
  output int unsigned events_due_o,
  output int unsigned parsed_bytes_o
);
  import dip_pkg::*;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharNine   = 8'h39;

  // code field reads zero on every event but an error
  localparam error_e NoCode = ERR_NO_BRACE;

  typedef struct {
    event_e      kind;
    logic [7:0]  data;
    logic [63:0] value;
    error_e      code;
    logic        last;
  } parse_event_t;

  parse_event_t          events_due_q[$];
  phase_e                phase;
  escape_e               esc;
  logic [3:0]            hex_hi;
  logic [63:0]           acc;
  logic [LenWidth-1:0]   str_len;
  logic                  comma_seen;
  int unsigned           mismatches;
  int unsigned           parsed;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= CharLowerA && c <= CharLowerZ) || (c >= CharUpperA && c <= CharUpperZ);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= CharLowerA && c <= CharLowerF) return int'(c - CharLowerA) + 10;
    if (c >= CharUpperA && c <= CharUpperF) return int'(c - CharUpperA) + 10;
    if (is_digit(c)) return int'(c - CharZero);
    return -1;
  endfunction

  task automatic clear_parser();
    phase      = PH_OPEN;
    esc        = ESC_NONE;
    hex_hi     = '0;
    acc        = '0;
    str_len    = '0;
    comma_seen = 1'b0;
  endtask

  task automatic queue_event(event_e kind, logic [7:0] data, logic [63:0] value, error_e code);
    parse_event_t ev;
    ev.kind  = kind;
    ev.data  = data;
    ev.value = value;
    ev.code  = code;
    ev.last  = 1'b0;
    events_due_q.push_back(ev);
  endtask

  task automatic raise_error(error_e code);
    queue_event(EV_ERROR, '0, '0, code);
    phase = PH_FAILED;
  endtask

  task automatic decoded_byte(logic [7:0] b);
    if (str_len >= MaxStringBytes) begin
      raise_error(ERR_TOO_LONG);
    end else begin
      str_len++;
      queue_event(EV_STR_BYTE, b, '0, NoCode);
    end
  endtask

  task automatic judge_after_value(logic [7:0] c);
    if (!comma_seen) begin
      if (c == CharComma) begin
        comma_seen = 1'b1;
        phase      = PH_AFTER;
      end else if (c == CharRBrace) begin
        queue_event(EV_DONE, '0, '0, NoCode);
        phase = PH_DONE;
      end else begin
        raise_error(ERR_NO_COMMA);
      end
    end else begin
      if (c == CharRBrace) begin
        queue_event(EV_DONE, '0, '0, NoCode);
        phase = PH_DONE;
      end else if (c == CharDot) begin
        comma_seen = 1'b0;
        phase      = PH_ID_FIRST;
      end else begin
        raise_error(ERR_NO_DOT);
      end
    end
  endtask

  task automatic string_char(logic [7:0] c);
    int h;
    case (esc)
      ESC_NONE: begin
        if (c == CharQuote) begin
          queue_event(EV_STR_END, '0, '0, NoCode);
          comma_seen = 1'b0;
          phase      = PH_AFTER;
        end else if (c == CharBackslash) begin
          esc = ESC_PENDING;
        end else begin
          decoded_byte(c);
        end
      end
      ESC_PENDING: begin
        // a second backslash leaves the escape pending
        if (c != CharBackslash) begin
          esc = ESC_NONE;
          if (c == CharQuote) decoded_byte(CharQuote);
          else if (c == CharLowerN) decoded_byte(ByteNewline);
          else if (c == CharLowerR) decoded_byte(ByteReturn);
          else if (c == CharZero) decoded_byte(ByteNul);
          else if (c == CharLowerX) esc = ESC_HEX_HI;
          else raise_error(ERR_BAD_ESCAPE);
        end
      end
      ESC_HEX_HI: begin
        h = hex_digit(c);
        if (h < 0) begin
          raise_error(ERR_BAD_HEX);
        end else begin
          hex_hi = 4'(h);
          esc    = ESC_HEX_LO;
        end
      end
      default: begin
        h   = hex_digit(c);
        esc = ESC_NONE;
        if (h < 0) raise_error(ERR_BAD_HEX);
        else decoded_byte({hex_hi, 4'(h)});
      end
    endcase
  endtask

  task automatic predict_byte(logic [7:0] c, logic first, logic last);
    int unsigned  mark;
    parse_event_t tail;
    mark = events_due_q.size();
    if (first) clear_parser();
    // finished text: bytes are dropped until the next restart
    if (phase == PH_DONE || phase == PH_FAILED) return;
    parsed++;
    case (phase)
      PH_OPEN: begin
        if (c == CharLBrace) phase = PH_DOT;
        else raise_error(ERR_NO_BRACE);
      end
      PH_DOT: begin
        if (c == CharDot) phase = PH_ID_FIRST;
        else raise_error(ERR_NO_DOT);
      end
      PH_ID_FIRST: begin
        if (is_letter(c)) begin
          queue_event(EV_NAME_BYTE, c, '0, NoCode);
          phase = PH_ID_REST;
        end else begin
          raise_error(ERR_BAD_NAME);
        end
      end
      PH_ID_REST: begin
        if (is_letter(c) || is_digit(c) || c == CharDollar || c == CharUnder) begin
          queue_event(EV_NAME_BYTE, c, '0, NoCode);
        end else begin
          queue_event(EV_NAME_END, '0, '0, NoCode);
          if (c == CharEquals) phase = PH_VALUE;
          else raise_error(ERR_NO_EQUALS);
        end
      end
      PH_VALUE: begin
        if (c == CharQuote) begin
          esc     = ESC_NONE;
          str_len = '0;
          phase   = PH_STRING;
        end else if (is_digit(c)) begin
          acc   = 64'(c - CharZero);
          phase = PH_NUMBER;
        end else begin
          raise_error(ERR_BAD_VALUE);
        end
      end
      PH_STRING: string_char(c);
      PH_NUMBER: begin
        if (is_digit(c)) begin
          acc = acc * 64'd10 + 64'(c - CharZero);
        end else begin
          // the number goes out first, then this byte is judged as a separator
          queue_event(EV_NUMBER, '0, acc, NoCode);
          comma_seen = 1'b0;
          judge_after_value(c);
        end
      end
      default: judge_after_value(c);
    endcase
    if (last && phase != PH_DONE && phase != PH_FAILED) begin
      if (phase == PH_NUMBER) queue_event(EV_NUMBER, '0, acc, NoCode);
      raise_error(ERR_TRUNCATED);
    end
    if (events_due_q.size() > mark) begin
      tail      = events_due_q.pop_back();
      tail.last = 1'b1;
      events_due_q.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parse_event_t ev;
    logic         bad;
    if (!rst_ni) begin
      clear_parser();
      events_due_q.delete();
      mismatches = 0;
      parsed     = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (events_due_q.size() == 0) begin
          $display("%0t: unexpected event, kind %0d", $time, out_mon.event_kind);
          mismatches++;
        end else begin
          ev  = events_due_q.pop_front();
          bad = 1'b0;
          if (out_mon.event_kind !== ev.kind) begin
            $display("%0t: event kind expected %0d got %0d", $time, ev.kind,
                     out_mon.event_kind);
            bad = 1'b1;
          end
          if (out_mon.out_byte !== ev.data) begin
            $display("%0t: out byte expected %02h got %02h", $time, ev.data, out_mon.out_byte);
            bad = 1'b1;
          end
          if (out_mon.number_value !== ev.value) begin
            $display("%0t: number expected %0d got %0d", $time, ev.value,
                     out_mon.number_value);
            bad = 1'b1;
          end
          if (out_mon.error_code !== ev.code) begin
            $display("%0t: error code expected %0d got %0d", $time, ev.code,
                     out_mon.error_code);
            bad = 1'b1;
          end
          if (out_mon.last_result !== ev.last) begin
            $display("%0t: last result expected %0b got %0b", $time, ev.last,
                     out_mon.last_result);
            bad = 1'b1;
          end
          if (bad) mismatches++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_byte(in_mon.data_byte, in_mon.first_byte, in_mon.last_byte);
      end
    end
    mismatch_count_o <= mismatches;
    events_due_o     <= events_due_q.size();
    parsed_bytes_o   <= parsed;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench top: byte stimulus, output stalls and the pass/fail verdict
module tb;
  import dip_pkg::*;

  // parsed bytes of random text before the run winds down
  localparam int unsigned RandomBytes = 1550;
  // length of the one long receiver hold-off
  localparam int unsigned HoldCycles  = 60;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;

  logic clk_i;
  logic rst_ni;

  dip_in_if  in_ch ();
  dip_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned events_due;
  int unsigned parsed_bytes;

  // text being sent, one byte per transaction
  logic [7:0]  text_q[$];
  // transactions left in the current sender burst
  int unsigned burst_left;
  // hold-off requests raised by the sender side and served by the receiver side
  int unsigned hold_asks = 0;
  int unsigned holds_served = 0;

  designated_initializer_parser_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // watches both channels, predicts every event and compares
  dip_event_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatch_count),
    .events_due_o     (events_due),
    .parsed_bytes_o   (parsed_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // receiver: ready walks the bits of a random eight-bit stall mask, all ones a quarter
  // of the time and re-drawn when its age count runs out; a hold-off request drops ready
  // for a long stretch so the result queue fills and input ready falls
  initial begin : receiver
    logic [7:0]  stall_mask;
    int unsigned age;
    int unsigned pos;
    stall_mask = 8'hFF;
    age        = 0;
    pos        = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_served) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_served++;
      end else begin
        if (age == 0) begin
          stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
          age        = 64;
        end
        out_ch.ready <= stall_mask[pos];
        pos = (pos + 1) % 8;
        age--;
      end
    end
  end

  // one input transaction; bursts of random length with idle gaps between them,
  // now and then a long burst with no gap at all
  task automatic send_byte(logic [7:0] b, logic first, logic last);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) :
                                                 $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= first;
    in_ch.last_byte  <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // sends text_q up to and including last_at with the end-of-buffer flag there,
  // or the whole text without the flag when last_at is negative
  task automatic send_text(logic with_first, int last_at);
    int stop;
    stop = (last_at >= 0) ? last_at : int'(text_q.size()) - 1;
    for (int i = 0; i <= stop; i++) begin
      send_byte(text_q[i], with_first && i == 0, last_at >= 0 && i == last_at);
    end
  endtask

  task automatic send_string(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text(1'b1, int'(text_q.size()) - 1);
  endtask

  // idle the input until every predicted event has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (events_due != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) ? CharUpperA : CharLowerA) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_digit();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return CharZero + 8'(r);
    if (r < 16) return CharLowerA + 8'(r - 10);
    return CharUpperA + 8'(r - 16);
  endfunction

  // any byte that stays literal inside a string
  function automatic logic [7:0] pick_raw();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CharQuote || b == CharBackslash) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 3))
      0:       return CharQuote;
      1:       return CharLowerN;
      2:       return CharLowerR;
      default: return CharZero;
    endcase
  endfunction

  task automatic add_name();
    text_q.push_back(pick_letter());
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(pick_letter());
        1:       text_q.push_back(pick_digit());
        2:       text_q.push_back(CharDollar);
        default: text_q.push_back(CharUnder);
      endcase
    end
  endtask

  task automatic add_number();
    string s;
    case ($urandom_range(0, 5))
      0: begin
        // largest value and the first one that wraps to zero
        s = $urandom_range(0, 1) ? "18446744073709551615" : "18446744073709551616";
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      end
      1:       repeat ($urandom_range(19, 22)) text_q.push_back(pick_digit());
      default: repeat ($urandom_range(1, 6)) text_q.push_back(pick_digit());
    endcase
  endtask

  task automatic add_string();
    text_q.push_back(CharQuote);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0: begin
          text_q.push_back(CharBackslash);
          text_q.push_back(pick_escape());
        end
        1: begin
          // doubled backslash keeps the escape pending
          text_q.push_back(CharBackslash);
          text_q.push_back(CharBackslash);
          text_q.push_back(pick_escape());
        end
        2: begin
          text_q.push_back(CharBackslash);
          text_q.push_back(CharLowerX);
          text_q.push_back(pick_hex());
          text_q.push_back(pick_hex());
        end
        default: text_q.push_back(pick_raw());
      endcase
    end
    text_q.push_back(CharQuote);
  endtask

  // initializer with 1 to 4 well-formed elements and an optional trailing comma, or now and then empty braces
  task automatic build_initializer();
    int unsigned n;
    text_q.delete();
    text_q.push_back(CharLBrace);
    if ($urandom_range(0, 29) != 0) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        text_q.push_back(CharDot);
        add_name();
        text_q.push_back(CharEquals);
        if ($urandom_range(0, 1)) add_number();
        else add_string();
        if (i != n - 1 || $urandom_range(0, 2) == 0) text_q.push_back(CharComma);
      end
    end
    text_q.push_back(CharRBrace);
  endtask

  task automatic build_noise();
    text_q.delete();
    if ($urandom_range(0, 1)) text_q.push_back(CharLBrace);
    repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // one string at the length limit: its last allowed byte comes from a hex
  // escape and the byte after it overflows
  task automatic build_long_string();
    text_q.delete();
    text_q.push_back(CharLBrace);
    text_q.push_back(CharDot);
    text_q.push_back(pick_letter());
    text_q.push_back(CharEquals);
    text_q.push_back(CharQuote);
    repeat (MaxStringBytes - 1) text_q.push_back(pick_raw());
    text_q.push_back(CharBackslash);
    text_q.push_back(CharLowerX);
    text_q.push_back(pick_hex());
    text_q.push_back(pick_hex());
    repeat (2) text_q.push_back(pick_raw());
    text_q.push_back(CharQuote);
    text_q.push_back(CharRBrace);
  endtask

  initial begin : stimulus
    logic long_sent;
    logic hold_sent;
    logic pause_sent;
    long_sent  = 1'b0;
    hold_sent  = 1'b0;
    pause_sent = 1'b0;
    burst_left = 0;
    rst_ni     = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty braces, a name with a dollar, underscore and digit in its tail
    // and a string with a doubled backslash, a newline escape and mixed-case hex plus
    // a trailing comma, a number cut off by the end of the buffer, and an all-ones
    // byte where the open brace belongs
    send_string("{}");
    send_string("{.z$_9=\"\\\\n\\xfF\",}");
    send_string("{.Q=0");
    send_byte(8'hFF, 1'b1, 1'b1);
    wait_drained();

    // random texts: mostly well formed, the rest noise, corrupted, truncated,
    // missing the restart flag or missing the end-of-buffer flag
    while (parsed_bytes < RandomBytes) begin
      if (!long_sent && parsed_bytes > 400) begin
        long_sent = 1'b1;
        build_long_string();
        send_text(1'b1, int'(text_q.size()) - 1);
      end
      if (!hold_sent && parsed_bytes > 600) begin
        // receiver holds off while an event-heavy text keeps coming
        hold_sent = 1'b1;
        hold_asks++;
        burst_left = 200;
        send_string("{.abcdefghij=\"0123456789\",.k=7}");
      end
      if (!pause_sent && parsed_bytes > 1000) begin
        pause_sent = 1'b1;
        wait_drained();
      end
      case ($urandom_range(0, 19))
        0, 1: begin
          build_noise();
          send_text(1'b1, $urandom_range(0, 1) ? int'(text_q.size()) - 1 : -1);
        end
        2, 3: begin
          build_initializer();
          text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
          send_text(1'b1, int'(text_q.size()) - 1);
        end
        4, 5: begin
          build_initializer();
          send_text(1'b1, $urandom_range(0, text_q.size() - 1));
        end
        6: begin
          build_initializer();
          send_text(1'b0, -1);
        end
        default: begin
          build_initializer();
          send_text(1'b1, $urandom_range(0, 1) ? int'(text_q.size()) - 1 : -1);
        end
      endcase
    end

    wait_drained();
    // a few more cycles to catch any stray event
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
